### hdl/fic_pkg.sv
// Shared types and constants for the frame index cache lookup block.
// No dependencies; fic_regs, fic_ctrl, fic_dpath and the top level import this package.
package fic_pkg;

  // Request command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_MINUTE = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FETCH   = 2'd2;
  localparam logic [1:0] ST_FILL    = 2'd3;

  // Classification of a request, found in the evaluate step
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_INVALID = 3'd0;
  localparam logic [KIND_W-1:0] K_HIT     = 3'd1;
  localparam logic [KIND_W-1:0] K_MISS    = 3'd2;
  localparam logic [KIND_W-1:0] K_FILL    = 3'd3;
  localparam logic [KIND_W-1:0] K_MINUTE  = 3'd4;

  // Register map, index = paddr[4:2]
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_VIDEO_ACTIVE = 3'd0;
  localparam logic [2:0] REG_OBFUSCATED   = 3'd1;
  localparam logic [2:0] REG_NUM_FRAMES   = 3'd2;
  localparam logic [2:0] REG_NUM_MINUTES  = 3'd3;
  localparam logic [2:0] REG_INDEX_BASE   = 3'd4;

  // Hash keys
  localparam logic [31:0] MIX_MUL_A   = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B   = 32'h846ca68b;
  localparam logic [31:0] FRAME_SEED  = 32'h4d335649;
  localparam logic [31:0] MINUTE_SEED = 32'h7258744d;

  typedef struct packed {
    logic        video_active;
    logic        obfuscated;
    logic [31:0] num_frames;
    logic [31:0] num_minutes;
    logic [31:0] index_base;
  } cfg_t;

  typedef struct packed {
    logic load;    // capture request word
    logic eval;    // classify request
    logic rd;      // read cache entry
    logic hinit;   // seed hash
    logic hmul1;   // first multiply
    logic hmul2;   // second multiply
    logic finish;  // commit state, load response register
  } ctl_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              obfuscated;
    logic              out_free;
  } ctl_sts_t;

endpackage

### hdl/fic_if.sv
// Request and response channel interfaces for the frame index cache lookup.
// Depends on nothing; the response payload widths follow the block parameters.
interface fic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] item_index;
  logic [31:0] rom_word;

  modport source (output valid, output cmd, output item_index, output rom_word, input ready);
  modport sink (input valid, input cmd, input item_index, input rom_word, output ready);
endinterface

interface fic_out_if #(
  parameter int WINDOW_BITS = 25,
  parameter int FETCH_W     = 9
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [31:0]            result_value;
  logic [2:0]             bank;
  logic [WINDOW_BITS-1:0] window_offset;
  logic [31:0]            fetch_address;
  logic [FETCH_W-1:0]     fetch_words;

  modport source (output valid, output status, output result_value, output bank,
                  output window_offset, output fetch_address, output fetch_words,
                  input ready);
  modport sink (input valid, input status, input result_value, input bank,
                input window_offset, input fetch_address, input fetch_words,
                output ready);
endinterface

### hdl/fic_regs.sv
// Configuration register file behind the APB-style port.
// Depends on fic_pkg for the register map and the cfg_t bundle.
module fic_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [fic_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output fic_pkg::cfg_t         cfg,
  output logic                  cfg_wr
);
  import fic_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (idx)
      REG_VIDEO_ACTIVE, REG_OBFUSCATED, REG_NUM_FRAMES,
      REG_NUM_MINUTES, REG_INDEX_BASE: cfg_wr = wr_en;
      default: cfg_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_VIDEO_ACTIVE: cfg.video_active <= pwdata[0];
        REG_OBFUSCATED:   cfg.obfuscated   <= pwdata[0];
        REG_NUM_FRAMES:   cfg.num_frames   <= pwdata;
        REG_NUM_MINUTES:  cfg.num_minutes  <= pwdata;
        REG_INDEX_BASE:   cfg.index_base   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_VIDEO_ACTIVE: prdata = {31'd0, cfg.video_active};
      REG_OBFUSCATED:   prdata = {31'd0, cfg.obfuscated};
      REG_NUM_FRAMES:   prdata = cfg.num_frames;
      REG_NUM_MINUTES:  prdata = cfg.num_minutes;
      REG_INDEX_BASE:   prdata = cfg.index_base;
      default:          prdata = '0;
    endcase
  end
endmodule

### hdl/fic_ctrl.sv
// Sequencing state machine: steps one request through evaluate, hash (obfuscated fill and minute only) and finish.
// Depends on fic_pkg for the command and status bundles.
module fic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  fic_pkg::ctl_sts_t sts,
  output fic_pkg::ctl_cmd_t cmd
);
  import fic_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_HASH1 = 3'd2;
  localparam logic [2:0] S_HASH2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.rd   = (sts.kind == K_HIT);
        if (sts.obfuscated && (sts.kind == K_FILL || sts.kind == K_MINUTE)) begin
          cmd.hinit  = 1'b1;
          state_next = S_HASH1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_HASH1: begin
        cmd.hmul1  = 1'b1;
        state_next = S_HASH2;
      end
      S_HASH2: begin
        cmd.hmul2  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the response register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

### hdl/fic_dpath.sv
// Datapath: request registers, block cache memory, fill tracking, hash and
// response register. Depends on fic_pkg; driven by fic_ctrl commands.
module fic_dpath #(
  parameter int CACHE_DEPTH = 256,
  parameter int WINDOW_BITS = 25
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fic_pkg::cfg_t             cfg,
  input  logic                      cfg_wr,
  input  fic_pkg::ctl_cmd_t         cmd,
  output fic_pkg::ctl_sts_t         sts,
  input  logic [1:0]                req_cmd,
  input  logic [31:0]               req_item,
  input  logic [31:0]               req_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [31:0]               out_value,
  output logic [2:0]                out_bank,
  output logic [WINDOW_BITS-1:0]    out_window,
  output logic [31:0]               out_fetch_addr,
  output logic [$clog2(CACHE_DEPTH):0] out_fetch_words
);
  import fic_pkg::*;

  localparam int AW = $clog2(CACHE_DEPTH);
  localparam int FW = AW + 1;

  logic [31:0]       mem [CACHE_DEPTH];
  logic [1:0]        cmd_q;
  logic [31:0]       item_q, word_q;
  logic [KIND_W-1:0] kind_q, kind_c;
  logic [31:0]       hreg, rdata;
  logic [31:0]       cached_first, fill_first;
  logic [FW-1:0]     cached_frames, fill_total, fill_pos;
  logic              fill_pending;

  logic [31:0] diff, hx, hmix, prod1, prod2, mask, decoded, minute_f;
  logic [31:0] start, remain, fetch_addr;
  logic [FW-1:0] count, pos_inc;
  logic        hit;

  // cache hit test against the completed block
  assign diff = item_q - cached_first;
  assign hit  = (item_q >= cached_first) && (diff < {{(32-FW){1'b0}}, cached_frames});

  always_comb begin
    case (cmd_q)
      CMD_LOOKUP: begin
        if (!cfg.video_active || item_q >= cfg.num_frames) kind_c = K_INVALID;
        else if (hit) kind_c = K_HIT;
        else kind_c = K_MISS;
      end
      CMD_FILL:   kind_c = fill_pending ? K_FILL : K_INVALID;
      CMD_MINUTE: begin
        if (!cfg.video_active || item_q >= cfg.num_minutes) kind_c = K_INVALID;
        else kind_c = K_MINUTE;
      end
      default:    kind_c = K_INVALID;
    endcase
  end

  assign sts.kind       = kind_c;
  assign sts.obfuscated = cfg.obfuscated;
  assign sts.out_free   = !out_valid || out_ready;

  // hash: seed, two multiplies, final fold
  assign hx    = (cmd_q == CMD_FILL) ? (FRAME_SEED ^ (fill_first + {{(32-FW){1'b0}}, fill_pos}))
                                     : (MINUTE_SEED ^ item_q);
  assign prod1 = hreg * MIX_MUL_A;
  assign prod2 = (hreg ^ (hreg >> 15)) * MIX_MUL_B;
  assign hmix  = hreg ^ (hreg >> 16);
  assign mask  = cfg.obfuscated ? hmix : 32'd0;
  assign decoded = word_q ^ mask;

  always_comb begin
    if (cfg.num_frames == 32'd0) minute_f = 32'd0;
    else if (decoded >= cfg.num_frames) minute_f = cfg.num_frames - 32'd1;
    else minute_f = decoded;
  end

  // miss: aligned block start and clamped word count
  assign start      = {item_q[31:AW], {AW{1'b0}}};
  assign remain     = cfg.num_frames - start;
  assign count      = (remain > 32'(CACHE_DEPTH)) ? FW'(CACHE_DEPTH) : remain[FW-1:0];
  assign fetch_addr = cfg.index_base + {start[29:0], 2'b00};
  assign pos_inc    = fill_pos + FW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= req_cmd;
      item_q <= req_item;
      word_q <= req_word;
    end
    if (cmd.eval) kind_q <= kind_c;
    if (cmd.hinit) hreg <= hx ^ (hx >> 16);
    else if (cmd.hmul1) hreg <= prod1;
    else if (cmd.hmul2) hreg <= prod2;
  end

  // cache memory
  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[diff[AW-1:0]];
    if (cmd.finish && kind_q == K_FILL) mem[fill_pos[AW-1:0]] <= decoded;
  end

  // block and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cached_first  <= '1;
      cached_frames <= '0;
      fill_first    <= '0;
      fill_total    <= '0;
      fill_pos      <= '0;
      fill_pending  <= 1'b0;
    end else if (cfg_wr) begin
      // any register write drops the cache and the fill
      cached_first  <= '1;
      cached_frames <= '0;
      fill_pos      <= '0;
      fill_pending  <= 1'b0;
    end else if (cmd.finish && kind_q == K_MISS) begin
      cached_first  <= '1;
      cached_frames <= '0;
      fill_first    <= start;
      fill_total    <= count;
      fill_pos      <= '0;
      fill_pending  <= 1'b1;
    end else if (cmd.finish && kind_q == K_FILL) begin
      fill_pos <= pos_inc;
      if (pos_inc >= fill_total) begin
        fill_pending  <= 1'b0;
        cached_first  <= fill_first;
        cached_frames <= fill_total;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (kind_q)
        K_HIT: begin
          out_status      <= ST_OK;
          out_value       <= rdata;
          out_bank        <= rdata[WINDOW_BITS+2 -: 3];
          out_window      <= rdata[WINDOW_BITS-1:0];
          out_fetch_addr  <= '0;
          out_fetch_words <= '0;
        end
        K_MISS: begin
          out_status      <= ST_FETCH;
          out_value       <= '0;
          out_bank        <= '0;
          out_window      <= '0;
          out_fetch_addr  <= fetch_addr;
          out_fetch_words <= count;
        end
        K_FILL: begin
          out_status      <= ST_FILL;
          out_value       <= decoded;
          out_bank        <= '0;
          out_window      <= '0;
          out_fetch_addr  <= '0;
          out_fetch_words <= '0;
        end
        K_MINUTE: begin
          out_status      <= ST_OK;
          out_value       <= minute_f;
          out_bank        <= '0;
          out_window      <= '0;
          out_fetch_addr  <= '0;
          out_fetch_words <= '0;
        end
        default: begin
          out_status      <= ST_INVALID;
          out_value       <= '0;
          out_bank        <= '0;
          out_window      <= '0;
          out_fetch_addr  <= '0;
          out_fetch_words <= '0;
        end
      endcase
    end
  end
endmodule

### hdl/frame_index_cache_lookup.sv
// Frame index cache lookup, top level.
// Joins the register file, the sequencer and the datapath; depends on
// fic_pkg, fic_if, fic_regs, fic_ctrl and fic_dpath.
//
// Usage:
//   req carries one request word: cmd, item_index, rom_word. A frame lookup
//   answers with the cached ROM offset (status ok) or, on a miss, with the
//   aligned block's fetch address and word count (status fetch). The caller
//   then sends the block's ROM words as fill commands, each answered with
//   status fill. A minute command decodes and clamps one minute-index word.
//   rsp carries one response word per request, in request order.
//   The user must write registers over the APB port only while the block is
//   idle (the block does not enforce it); every write drops the cached block
//   and any fill in progress.
// Sequencing: one request at a time; the request is evaluated, then finished,
//   with the two chained hash multiplies, one per cycle, between them when
//   obfuscation is on for fill and minute commands. The next request is
//   accepted only after the response register is loaded.
// Reset (synchronous, rst high): registers clear, cache empties, no fill is
//   pending. Cache contents are not cleared and need no clearing pass.
// Stall: a response waits in the output register while rsp.ready is low;
//   a following request is still accepted and runs until its response is
//   ready, then holds.
module frame_index_cache_lookup #(
  parameter int CACHE_DEPTH = 256,
  parameter int WINDOW_BITS = 25
) (
  input  logic        clk,
  input  logic        rst,
  fic_in_if.sink      req,
  fic_out_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [fic_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fic_pkg::*;

  cfg_t     cfg;
  logic     cfg_wr;
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  fic_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  fic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // response register lives in the datapath; drive the channel from it
  fic_dpath #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cfg_wr          (cfg_wr),
    .cmd             (cmd),
    .sts             (sts),
    .req_cmd         (req.cmd),
    .req_item        (req.item_index),
    .req_word        (req.rom_word),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_status      (rsp.status),
    .out_value       (rsp.result_value),
    .out_bank        (rsp.bank),
    .out_window      (rsp.window_offset),
    .out_fetch_addr  (rsp.fetch_address),
    .out_fetch_words (rsp.fetch_words)
  );
endmodule
